### hdl/ilw_pkg.sv
// Shared types, constants and elaboration-time tables for the IRLS loss weight block.
package ilw_pkg;

	// Data format
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ALPHA_FRAC = 16;
	localparam int LOGI_LIMIT = 500;

	// Internal fixed point for the logistic path
	localparam int IQ           = 30;
	localparam int TERMS        = 20;
	localparam int RECIP_SHIFT  = 36;
	localparam int EN_IDX_W     = 5;
	localparam int EN_DEPTH     = 1 << EN_IDX_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DATA_WIDTH - 1;

	typedef logic [DATA_WIDTH-1:0]   word_t;
	typedef logic [2*DATA_WIDTH-1:0] dword_t;
	typedef logic [DATA_WIDTH-2:0]   tun_t;
	typedef logic [ALPHA_FRAC:0]     alpha_t;
	typedef logic [IQ:0]             q30_t;
	typedef logic [RECIP_SHIFT:0]    recip_t;
	typedef logic [2:0]              kind_t;
	typedef logic [2:0]              mode_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

	// Loss kinds
	localparam kind_t LOSS_QUANTILE = 3'd1;
	localparam kind_t LOSS_SQUARE   = 3'd2;
	localparam kind_t LOSS_HUBER    = 3'd3;
	localparam kind_t LOSS_LOGISTIC = 3'd4;

	// Register indexes
	localparam cfg_idx_t CFG_LOSS_KIND = 2'd0;
	localparam cfg_idx_t CFG_QUANTILE  = 2'd1;
	localparam cfg_idx_t CFG_TUNING    = 2'd2;

	// How the final weight is formed
	localparam mode_t MODE_ZERO  = 3'd0;
	localparam mode_t MODE_CONST = 3'd1;
	localparam mode_t MODE_INF   = 3'd2;
	localparam mode_t MODE_DIV   = 3'd3;
	localparam mode_t MODE_LOG0  = 3'd4;
	localparam mode_t MODE_LOGN  = 3'd5;

	// tuser bit positions on the result side
	localparam int USER_INF = 0;
	localparam int USER_SAT = 1;

	localparam kind_t  KIND_RESET     = LOSS_SQUARE;
	localparam alpha_t ALPHA_ONE      = alpha_t'(1) << ALPHA_FRAC;
	localparam alpha_t QUANTILE_RESET = alpha_t'(1) << (ALPHA_FRAC - 1);
	localparam word_t  LOGI_MAG       = word_t'(LOGI_LIMIT) << FRAC_BITS;
	localparam int     QSHIFT         = 2 * FRAC_BITS - (ALPHA_FRAC + 1);
	localparam q30_t   IONE_Q         = q30_t'(1) << IQ;

	// floor(v / k) == (v * RECIP_TAB[k]) >> RECIP_SHIFT for every v below 2^31
	localparam logic [63:0] R_ONE = 64'd1 << RECIP_SHIFT;
	localparam recip_t RECIP_TAB [TERMS+2] = '{
		recip_t'(0),
		recip_t'(R_ONE),
		recip_t'((R_ONE + 64'd1) / 64'd2),
		recip_t'((R_ONE + 64'd2) / 64'd3),
		recip_t'((R_ONE + 64'd3) / 64'd4),
		recip_t'((R_ONE + 64'd4) / 64'd5),
		recip_t'((R_ONE + 64'd5) / 64'd6),
		recip_t'((R_ONE + 64'd6) / 64'd7),
		recip_t'((R_ONE + 64'd7) / 64'd8),
		recip_t'((R_ONE + 64'd8) / 64'd9),
		recip_t'((R_ONE + 64'd9) / 64'd10),
		recip_t'((R_ONE + 64'd10) / 64'd11),
		recip_t'((R_ONE + 64'd11) / 64'd12),
		recip_t'((R_ONE + 64'd12) / 64'd13),
		recip_t'((R_ONE + 64'd13) / 64'd14),
		recip_t'((R_ONE + 64'd14) / 64'd15),
		recip_t'((R_ONE + 64'd15) / 64'd16),
		recip_t'((R_ONE + 64'd16) / 64'd17),
		recip_t'((R_ONE + 64'd17) / 64'd18),
		recip_t'((R_ONE + 64'd18) / 64'd19),
		recip_t'((R_ONE + 64'd19) / 64'd20),
		recip_t'((R_ONE + 64'd20) / 64'd21)
	};

	// Alternating series accumulate: odd terms subtract, even terms add
	function automatic q30_t series_acc(input q30_t s, input q30_t t, input int k);
		return ((k % 2) == 1) ? q30_t'(s - t) : q30_t'(s + t);
	endfunction

	// exp(-x) on [0,1] in Q.30, same floors as the hardware series
	function automatic q30_t exp_neg_const(input q30_t x);
		q30_t sum;
		q30_t term;
		logic [127:0] prod;
		sum  = IONE_Q;
		term = IONE_Q;
		for (int k = 1; k <= TERMS; k++) begin
			prod = (128'(term) * 128'(x)) >> IQ;
			prod = (prod * 128'(RECIP_TAB[k])) >> RECIP_SHIFT;
			term = q30_t'(prod);
			sum  = series_acc(sum, term, k);
		end
		return sum;
	endfunction

	localparam q30_t E1 = exp_neg_const(IONE_Q);

	// exp(-n) for integer n as repeated floored products; zero from n = EN_DEPTH on
	typedef q30_t en_tab_t [EN_DEPTH];

	function automatic en_tab_t build_en_tab();
		en_tab_t tab;
		logic [63:0] en;
		en = 64'(IONE_Q);
		for (int i = 0; i < EN_DEPTH; i++) begin
			tab[i] = q30_t'(en);
			en = (en * 64'(E1)) >> IQ;
		end
		return tab;
	endfunction

	localparam en_tab_t EN_TAB = build_en_tab();

	// Sideband that travels with every item
	typedef struct packed {
		logic                 last;
		mode_t                mode;
		logic [FRAC_BITS:0]   cval;
		word_t                mag;
		q30_t                 en;
		dword_t               divn;
		word_t                divd;
		word_t                qa;
		logic                 sat;
	} tag_t;

	typedef struct packed {
		word_t weight;
		logic  inf;
		logic  sat;
		logic  last;
	} res_t;

endpackage

### hdl/ilw_taylor.sv
// Pipelined 20-term series for exp(-x) and (1-exp(-x))/x in Q.30.
module ilw_taylor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [ilw_pkg::IQ-1:0]    in_x,
	input  ilw_pkg::tag_t             in_tag,
	output logic                      out_valid,
	output ilw_pkg::q30_t             out_exp,
	output ilw_pkg::q30_t             out_ratio,
	output ilw_pkg::tag_t             out_tag
);
	import ilw_pkg::*;

	localparam int PROD_W  = 2 * IQ + 2;
	localparam int RPROD_W = IQ + RECIP_SHIFT + 2;

	// first half of each step: product with x; second half: divide by k (exp) or k+1 (ratio)
	logic          valid_s1    [1:TERMS];
	logic [IQ-1:0] x_s1        [1:TERMS];
	q30_t          exp_prod_s1 [1:TERMS];
	q30_t          rat_prod_s1 [1:TERMS];
	q30_t          exp_sum_s1  [1:TERMS];
	q30_t          rat_sum_s1  [1:TERMS];
	tag_t          tag_s1      [1:TERMS];

	logic          valid_s2    [1:TERMS];
	logic [IQ-1:0] x_s2        [1:TERMS];
	q30_t          exp_term_s2 [1:TERMS];
	q30_t          rat_term_s2 [1:TERMS];
	q30_t          exp_sum_s2  [1:TERMS];
	q30_t          rat_sum_s2  [1:TERMS];
	tag_t          tag_s2      [1:TERMS];

	logic valid_s3;
	q30_t exp_s3;
	q30_t rat_s3;
	tag_t tag_s3;

	for (genvar k = 1; k <= TERMS; k++) begin : g_step
		logic          v_in;
		logic [IQ-1:0] x_in;
		q30_t          et_in;
		q30_t          rt_in;
		q30_t          es_in;
		q30_t          rs_in;
		tag_t          t_in;

		if (k == 1) begin : g_head
			assign v_in  = in_valid;
			assign x_in  = in_x;
			assign et_in = IONE_Q;
			assign rt_in = IONE_Q;
			assign es_in = IONE_Q;
			assign rs_in = IONE_Q;
			assign t_in  = in_tag;
		end else begin : g_link
			assign v_in  = valid_s2[k-1];
			assign x_in  = x_s2[k-1];
			assign et_in = exp_term_s2[k-1];
			assign rt_in = rat_term_s2[k-1];
			assign es_in = series_acc(exp_sum_s2[k-1], exp_term_s2[k-1], k - 1);
			assign rs_in = series_acc(rat_sum_s2[k-1], rat_term_s2[k-1], k - 1);
			assign t_in  = tag_s2[k-1];
		end

		// valid bits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s1[k] <= 1'b0;
				valid_s2[k] <= 1'b0;
			end else if (en) begin
				valid_s1[k] <= v_in;
				valid_s2[k] <= valid_s1[k];
			end
		end

		// term * x, then floor divide by k (exp) and k+1 (ratio)
		always_ff @(posedge clk) begin
			if (en) begin
				x_s1[k]        <= x_in;
				exp_prod_s1[k] <= q30_t'((PROD_W'(et_in) * PROD_W'(x_in)) >> IQ);
				rat_prod_s1[k] <= q30_t'((PROD_W'(rt_in) * PROD_W'(x_in)) >> IQ);
				exp_sum_s1[k]  <= es_in;
				rat_sum_s1[k]  <= rs_in;
				tag_s1[k]      <= t_in;

				x_s2[k]        <= x_s1[k];
				exp_term_s2[k] <= q30_t'((RPROD_W'(exp_prod_s1[k]) *
					RPROD_W'(RECIP_TAB[k])) >> RECIP_SHIFT);
				rat_term_s2[k] <= q30_t'((RPROD_W'(rat_prod_s1[k]) *
					RPROD_W'(RECIP_TAB[k+1])) >> RECIP_SHIFT);
				exp_sum_s2[k]  <= exp_sum_s1[k];
				rat_sum_s2[k]  <= rat_sum_s1[k];
				tag_s2[k]      <= tag_s1[k];
			end
		end
	end

	// last accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2[TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exp_s3 <= series_acc(exp_sum_s2[TERMS], exp_term_s2[TERMS], TERMS);
			rat_s3 <= series_acc(rat_sum_s2[TERMS], rat_term_s2[TERMS], TERMS);
			tag_s3 <= tag_s2[TERMS];
		end
	end

	assign out_valid = valid_s3;
	assign out_exp   = exp_s3;
	assign out_ratio = rat_s3;
	assign out_tag   = tag_s3;

endmodule

### hdl/ilw_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64 by 32 bits.
module ilw_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  ilw_pkg::dword_t in_num,
	input  ilw_pkg::word_t  in_den,
	input  ilw_pkg::tag_t   in_tag,
	output logic            out_valid,
	output ilw_pkg::word_t  out_quo,
	output ilw_pkg::tag_t   out_tag
);
	import ilw_pkg::*;

	logic  valid_s [0:DATA_WIDTH];
	word_t rem_s   [0:DATA_WIDTH];
	word_t low_s   [0:DATA_WIDTH];
	word_t quo_s   [0:DATA_WIDTH];
	word_t den_s   [0:DATA_WIDTH];
	tag_t  tag_s   [0:DATA_WIDTH];

	// load: upper half is the starting remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= in_num[2*DATA_WIDTH-1:DATA_WIDTH];
			low_s[0] <= in_num[DATA_WIDTH-1:0];
			quo_s[0] <= '0;
			den_s[0] <= in_den;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_bit
		logic [DATA_WIDTH:0] trial;
		logic                fits;

		assign trial = {rem_s[i], low_s[i][DATA_WIDTH-1]};
		assign fits  = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		// shift in next dividend bit, subtract when it fits
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? word_t'(trial - {1'b0, den_s[i]})
				                   : trial[DATA_WIDTH-1:0];
				low_s[i+1] <= {low_s[i][DATA_WIDTH-2:0], 1'b0};
				quo_s[i+1] <= {quo_s[i][DATA_WIDTH-2:0], fits};
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = valid_s[DATA_WIDTH];
	assign out_quo   = quo_s[DATA_WIDTH];
	assign out_tag   = tag_s[DATA_WIDTH];

endmodule

### hdl/ilw_skid.sv
// Output register with one skid entry; holds the pipeline while both are full.
module ilw_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ilw_pkg::res_t in_data,
	output logic          adv,
	output logic          out_valid,
	input  logic          out_ready,
	output ilw_pkg::res_t out_data
);
	import ilw_pkg::*;

	logic o_valid_q;
	logic k_valid_q;
	res_t o_data_q;
	res_t k_data_q;

	// pipeline moves whenever the skid entry is free
	assign adv = !k_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			k_valid_q <= 1'b0;
		end else if (!o_valid_q || out_ready) begin
			if (k_valid_q) begin
				o_valid_q <= 1'b1;
				k_valid_q <= 1'b0;
			end else begin
				o_valid_q <= in_valid;
			end
		end else if (in_valid && !k_valid_q) begin
			k_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_valid_q || out_ready) begin
			o_data_q <= k_valid_q ? k_data_q : in_data;
		end else if (!k_valid_q) begin
			k_data_q <= in_data;
		end
	end

	assign out_valid = o_valid_q;
	assign out_data  = o_data_q;

`ifndef SYNTH
	// skid only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		k_valid_q |-> o_valid_q)
		else $error("skid entry valid with empty output register");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(k_valid_q && out_ready) |=> (!k_valid_q && o_valid_q))
		else $error("skid entry did not move to output");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(k_valid_q) |-> $past(o_valid_q && !out_ready && in_valid))
		else $error("skid filled without a stalled request");
`endif

endmodule

### hdl/irls_loss_weight.sv
// Top level: IRLS weight psi(t)/(2t) for quantile, square, Huber and logistic loss.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------
//  s_*      | s_tvalid / s_tready      | tdata residual, tlast is_last
//  m_*      | m_tvalid / m_tready      | tdata weight, tuser flags, tlast
//  cfg_*    | cfg_valid / cfg_ready    | cfg_index register, cfg_data value
//
//  One residual per clock while the skid entry is free. Stages: front stage, the 41-stage
//  series pipeline of the logistic path, one product stage, two 33-stage
//  dividers and the output register.
//  Reset clears all valid bits and loads the registers with their defaults.
//  A stalled m_tready parks one result in the skid entry; after that the whole
//  pipeline holds and s_tready drops until the skid entry drains.
module irls_loss_weight (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [31:0]              s_tdata,   // [31:0] residual
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,   // [31:0] weight
	output logic [1:0]               m_tuser,   // [0] is_infinite, [1] saturated
	output logic                     m_tlast,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  ilw_pkg::cfg_idx_t        cfg_index,
	input  logic [ilw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ilw_pkg::*;

	// configuration registers
	kind_t  loss_kind_q;
	alpha_t quantile_q;
	tun_t   tuning_q;

	logic pipe_en;

	logic   valid_s1;
	word_t  mag_s1;
	logic   neg_s1;
	kind_t  kind_s1;
	alpha_t alpha_s1;
	tun_t   tun_s1;
	logic   last_s1;

	tag_t          dec_tag;
	logic [IQ-1:0] dec_x;

	logic tay_valid;
	q30_t tay_exp;
	q30_t tay_ratio;
	tag_t tay_tag;

	logic valid_s2;
	q30_t e_s2;
	q30_t ratio_s2;
	tag_t tag_s2;

	dword_t d1_num;
	word_t  d1_den;
	tag_t   d1_tag_in;
	logic   d1_valid;
	word_t  d1_quo;
	tag_t   d1_tag;

	dword_t d2_num;
	word_t  d2_den;
	tag_t   d2_tag_in;
	logic   d2_valid;
	word_t  d2_quo;
	tag_t   d2_tag;

	res_t res_f;
	res_t res_out;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_kind_q <= KIND_RESET;
			quantile_q  <= QUANTILE_RESET;
			tuning_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOSS_KIND: loss_kind_q <= cfg_data[2:0];
				CFG_QUANTILE:  quantile_q  <= cfg_data[ALPHA_FRAC:0];
				CFG_TUNING:    tuning_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign s_tready = pipe_en;

	// front stage: magnitude and captured configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pipe_en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			neg_s1   <= s_tdata[DATA_WIDTH-1];
			mag_s1   <= s_tdata[DATA_WIDTH-1] ? word_t'(~s_tdata + 1'b1) : s_tdata;
			kind_s1  <= loss_kind_q;
			alpha_s1 <= (quantile_q > ALPHA_ONE) ? ALPHA_ONE : quantile_q;
			tun_s1   <= tuning_q;
			last_s1  <= s_tlast;
		end
	end

	// decode the loss case and the operands of the plain division cases
	always_comb begin
		logic tun_nz;
		logic le_tun;
		logic mag_zero;
		alpha_t a_sel;
		tun_nz   = tun_s1 != '0;
		le_tun   = mag_s1 <= {1'b0, tun_s1};
		mag_zero = mag_s1 == '0;
		a_sel    = neg_s1 ? alpha_t'(ALPHA_ONE - alpha_s1) : alpha_s1;

		dec_tag      = '0;
		dec_tag.last = last_s1;
		dec_tag.mag  = mag_s1;
		dec_tag.mode = MODE_ZERO;
		dec_tag.divd = word_t'(1);
		dec_tag.en   = (mag_s1[DATA_WIDTH-1:FRAC_BITS+EN_IDX_W] == '0)
		             ? EN_TAB[mag_s1[FRAC_BITS +: EN_IDX_W]] : '0;
		dec_x = {mag_s1[FRAC_BITS-1:0], (IQ-FRAC_BITS)'(0)};

		unique case (kind_s1)
			LOSS_QUANTILE: begin
				if (tun_nz && le_tun) begin
					dec_tag.mode = MODE_DIV;
					dec_tag.divn = dword_t'(alpha_s1) << QSHIFT;
					dec_tag.divd = word_t'(tun_s1);
				end else if (mag_zero) begin
					dec_tag.mode = MODE_INF;
				end else begin
					dec_tag.mode = MODE_DIV;
					dec_tag.divn = dword_t'(a_sel) << QSHIFT;
					dec_tag.divd = mag_s1;
				end
			end
			LOSS_SQUARE: begin
				dec_tag.mode = MODE_CONST;
				dec_tag.cval = (FRAC_BITS+1)'(1) << FRAC_BITS;
			end
			LOSS_HUBER: begin
				if (!tun_nz) begin
					if (mag_zero) begin
						dec_tag.mode = MODE_INF;
					end else begin
						dec_tag.mode = MODE_DIV;
						dec_tag.divn = dword_t'(1) << (2*FRAC_BITS - 1);
						dec_tag.divd = mag_s1;
					end
				end else if (le_tun) begin
					dec_tag.mode = MODE_CONST;
					dec_tag.cval = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
				end else begin
					dec_tag.mode = MODE_DIV;
					dec_tag.divn = dword_t'(tun_s1) << (FRAC_BITS - 1);
					dec_tag.divd = mag_s1;
				end
			end
			LOSS_LOGISTIC: begin
				if (mag_zero) begin
					dec_tag.mode = MODE_CONST;
					dec_tag.cval = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
				end else if (mag_s1 >= LOGI_MAG) begin
					dec_tag.mode = MODE_DIV;
					dec_tag.divn = dword_t'(1) << (2*FRAC_BITS);
					dec_tag.divd = mag_s1;
				end else if (mag_s1[DATA_WIDTH-1:FRAC_BITS] == '0) begin
					dec_tag.mode = MODE_LOG0;
				end else begin
					dec_tag.mode = MODE_LOGN;
				end
			end
			default: dec_tag.mode = MODE_ZERO;
		endcase
	end

	ilw_taylor u_taylor (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (valid_s1),
		.in_x      (dec_x),
		.in_tag    (dec_tag),
		.out_valid (tay_valid),
		.out_exp   (tay_exp),
		.out_ratio (tay_ratio),
		.out_tag   (tay_tag)
	);

	// e = exp(-n) * exp(-f)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pipe_en) begin
			valid_s2 <= tay_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			e_s2     <= q30_t'((dword_t'(tay_tag.en) * dword_t'(tay_exp)) >> IQ);
			ratio_s2 <= tay_ratio;
			tag_s2   <= tay_tag;
		end
	end

	// first division operands; overflow check for the plain division cases
	always_comb begin
		logic is_log;
		is_log    = (tag_s2.mode == MODE_LOG0) || (tag_s2.mode == MODE_LOGN);
		d1_den    = is_log ? word_t'(word_t'(IONE_Q) + word_t'(e_s2)) : tag_s2.divd;
		if (tag_s2.mode == MODE_LOG0) begin
			d1_num = dword_t'(ratio_s2) << IQ;
		end else if (tag_s2.mode == MODE_LOGN) begin
			d1_num = dword_t'(q30_t'(IONE_Q - e_s2)) << IQ;
		end else begin
			d1_num = tag_s2.divn;
		end
		d1_tag_in     = tag_s2;
		d1_tag_in.sat = (d1_den == '0) || (d1_num[2*DATA_WIDTH-1:DATA_WIDTH] >= d1_den);
	end

	ilw_div u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (valid_s2),
		.in_num    (d1_num),
		.in_den    (d1_den),
		.in_tag    (d1_tag_in),
		.out_valid (d1_valid),
		.out_quo   (d1_quo),
		.out_tag   (d1_tag)
	);

	// second division: tanh(t/2) scaled by 1/|t|
	always_comb begin
		d2_tag_in    = d1_tag;
		d2_tag_in.qa = d1_quo;
		if (d1_tag.mode == MODE_LOGN) begin
			d2_num = dword_t'(d1_quo) << 2;
			d2_den = d1_tag.mag;
		end else begin
			d2_num = '0;
			d2_den = word_t'(1);
		end
	end

	ilw_div u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (d1_valid),
		.in_num    (d2_num),
		.in_den    (d2_den),
		.in_tag    (d2_tag_in),
		.out_valid (d2_valid),
		.out_quo   (d2_quo),
		.out_tag   (d2_tag)
	);

	// result select
	always_comb begin
		res_f      = '0;
		res_f.last = d2_tag.last;
		unique case (d2_tag.mode)
			MODE_ZERO:  res_f.weight = '0;
			MODE_CONST: res_f.weight = word_t'(d2_tag.cval);
			MODE_INF: begin
				res_f.weight = '1;
				res_f.inf    = 1'b1;
			end
			MODE_DIV: begin
				res_f.weight = d2_tag.sat ? '1 : d2_tag.qa;
				res_f.sat    = d2_tag.sat;
			end
			MODE_LOG0:  res_f.weight = d2_tag.qa >> (IQ - FRAC_BITS);
			MODE_LOGN:  res_f.weight = d2_quo;
			default:    res_f.weight = '0;
		endcase
	end

	ilw_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d2_valid),
		.in_data   (res_f),
		.adv       (pipe_en),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out)
	);

	assign m_tdata           = res_out.weight;
	assign m_tuser[USER_INF] = res_out.inf;
	assign m_tuser[USER_SAT] = res_out.sat;
	assign m_tlast           = res_out.last;

`ifndef SYNTH
	a_inf_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[USER_INF]) |-> (&m_tdata))
		else $error("infinite weight not all ones");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[USER_INF] && m_tuser[USER_SAT]))
		else $error("infinite and saturated raised together");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && $past(!m_tready)))
		else $error("input stalled without a waiting result");
`endif

endmodule

### tb/sv/irls_loss_weight_check.sv
// Checker for the IRLS loss weight block: watches all channels, predicts each weight, compares.
`timescale 1ns / 100ps
module irls_loss_weight_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [31:0]                    s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [31:0]                    m_tdata,
	input  logic [1:0]                     m_tuser,
	input  logic                           m_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  ilw_pkg::cfg_idx_t              cfg_index,
	input  logic [ilw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             weights_pending,
	output int                             weights_seen
);
	import ilw_pkg::*;

	localparam logic [63:0] WMAX  = 64'hFFFF_FFFF;
	localparam logic [63:0] Q30   = 64'd1 << IQ;
	localparam logic [63:0] LIMIT = 64'd500 << FRAC_BITS;

	// shadow registers
	kind_t           sh_kind;
	logic [16:0]     sh_alpha;
	logic [30:0]     sh_tun;

	res_t weight_q[$];

	// floor(a * 2^s / d) saturated to the weight range
	function automatic logic [63:0] scaled_quot(input logic [63:0] a, input int s,
			input logic [63:0] d, inout logic sat);
		logic [63:0] q;
		logic [63:0] r;
		logic        b;
		if (d == 0) begin
			sat = 1'b1;
			return WMAX;
		end
		q = a / d;
		r = a % d;
		if (q > WMAX) begin
			sat = 1'b1;
			return WMAX;
		end
		for (int i = 0; i < s; i++) begin
			b = (r >= d - r);
			r = b ? (r - (d - r)) : (r << 1);
			if (q > (WMAX >> 1)) begin
				sat = 1'b1;
				return WMAX;
			end
			q = (q << 1) | 64'(b);
			if (q > WMAX) begin
				sat = 1'b1;
				return WMAX;
			end
		end
		return q;
	endfunction

	// alternating Taylor sum; denominators k+off, off 0 gives exp(-x), 1 gives (1-exp(-x))/x
	function automatic logic [63:0] taylor_q30(input logic [63:0] x, input int off);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = Q30;
		term = Q30;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * x) >> IQ) / 64'(k + off);
			if (k % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		return sum;
	endfunction

	// tanh(y/2)/y below the large-residual limit
	function automatic logic [63:0] tanh_ratio(input logic [63:0] mag, inout logic sat);
		logic [63:0] yq;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] e1;
		logic [63:0] en;
		logic [63:0] e;
		logic [63:0] th;
		yq = mag << (IQ - FRAC_BITS);
		n  = yq >> IQ;
		f  = yq & (Q30 - 1);
		e1 = taylor_q30(Q30, 0);
		en = Q30;
		for (logic [63:0] i = 0; i < n && en != 0; i++)
			en = (en * e1) >> IQ;
		e = (en * taylor_q30(f, 0)) >> IQ;
		if (n == 0)
			return ((taylor_q30(f, 1) << IQ) / (Q30 + e)) >> (IQ - FRAC_BITS);
		th = ((Q30 - e) << IQ) / (Q30 + e);
		return scaled_quot(th, FRAC_BITS, yq, sat);
	endfunction

	function automatic res_t predict_weight(input logic [31:0] t, input logic last);
		res_t        r;
		logic        neg;
		logic [63:0] mag;
		logic [63:0] alpha;
		logic [63:0] tun;
		logic [63:0] w;
		logic        inf;
		logic        sat;
		neg   = t[31];
		mag   = neg ? 64'(32'(-t)) : 64'(t);
		alpha = (sh_alpha > 17'(ALPHA_ONE)) ? 64'(ALPHA_ONE) : 64'(sh_alpha);
		tun   = 64'(sh_tun);
		w     = 0;
		inf   = 1'b0;
		sat   = 1'b0;
		case (sh_kind)
			LOSS_QUANTILE: begin
				if (tun != 0 && mag <= tun)
					w = scaled_quot(alpha, QSHIFT, tun, sat);
				else if (mag == 0)
					inf = 1'b1;
				else
					w = scaled_quot(neg ? (64'(ALPHA_ONE) - alpha) : alpha, QSHIFT, mag, sat);
			end
			LOSS_SQUARE: w = 64'd1 << FRAC_BITS;
			LOSS_HUBER: begin
				if (tun == 0) begin
					if (mag == 0) inf = 1'b1;
					else w = scaled_quot(64'd1, 2 * FRAC_BITS - 1, mag, sat);
				end else if (mag <= tun) begin
					w = 64'd1 << (FRAC_BITS - 1);
				end else begin
					w = scaled_quot(tun, FRAC_BITS - 1, mag, sat);
				end
			end
			LOSS_LOGISTIC: begin
				if (mag == 0) w = 64'd1 << (FRAC_BITS - 1);
				else if (mag >= LIMIT) w = scaled_quot(64'd1, 2 * FRAC_BITS, mag, sat);
				else w = tanh_ratio(mag, sat);
			end
			default: w = 0;
		endcase
		if (inf || sat) w = WMAX;
		r.weight = w[31:0];
		r.inf    = inf;
		r.sat    = sat;
		r.last   = last;
		return r;
	endfunction

	// register writes, accepted residuals and returned weights
	always @(posedge clk or negedge arst_n) begin
		res_t exp_w;
		if (!arst_n) begin
			sh_kind         <= KIND_RESET;
			sh_alpha        <= QUANTILE_RESET;
			sh_tun          <= '0;
			fail_count      <= 0;
			weights_pending <= 0;
			weights_seen    <= 0;
			weight_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOSS_KIND: sh_kind  <= cfg_data[2:0];
					CFG_QUANTILE:  sh_alpha <= cfg_data[16:0];
					CFG_TUNING:    sh_tun   <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				weight_q.push_back(predict_weight(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				weights_seen <= weights_seen + 1;
				if (weight_q.size() == 0) begin
					$error("weight returned with no residual outstanding: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = weight_q.pop_front();
					if (m_tdata !== exp_w.weight || m_tuser[USER_INF] !== exp_w.inf ||
							m_tuser[USER_SAT] !== exp_w.sat || m_tlast !== exp_w.last)
						fail_count <= fail_count + 1;
					if (m_tdata !== exp_w.weight)
						$error("weight: expected %h, got %h", exp_w.weight, m_tdata);
					if (m_tuser[USER_INF] !== exp_w.inf)
						$error("is_infinite: expected %b, got %b", exp_w.inf, m_tuser[USER_INF]);
					if (m_tuser[USER_SAT] !== exp_w.sat)
						$error("saturated: expected %b, got %b", exp_w.sat, m_tuser[USER_SAT]);
					if (m_tlast !== exp_w.last)
						$error("is_last_out: expected %b, got %b", exp_w.last, m_tlast);
				end
			end
			weights_pending <= weight_q.size();
		end
	end

endmodule

### tb/sv/irls_loss_weight_test.sv
// Top of the IRLS loss weight testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module irls_loss_weight_test;
	import ilw_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;   // [31:0] residual
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;   // [31:0] weight
	logic [1:0]            m_tuser;   // [0] is_infinite, [1] saturated
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  fail_count;
	int  weights_pending;
	int  weights_seen;
	int  residuals_sent;
	int  phases_run;
	bit  no_idle;
	logic [30:0] cur_tun;

	irls_loss_weight DUT (.*);

	irls_loss_weight_check checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	initial begin
		#5ms;
		$display("[irls_loss_weight] ERROR");
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			@(posedge clk iff m_tvalid);
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk iff cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_residual(input logic [31:0] t, input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		s_tlast  <= last;
		@(posedge clk iff s_tready);
		@(negedge clk);
		residuals_sent++;
	endtask

	task automatic drain;
		if (s_tvalid) s_tvalid <= 1'b0;
		wait (weights_pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_loss(input kind_t k, input logic [16:0] a, input logic [30:0] tn);
		drain();
		write_reg(CFG_LOSS_KIND, CFG_DATA_W'(k));
		write_reg(CFG_QUANTILE, CFG_DATA_W'(a));
		write_reg(CFG_TUNING, tn);
		cur_tun = tn;
		phases_run++;
	endtask

	// residual with emphasis on zero, the tuning edge and the logistic ranges
	function automatic logic [31:0] pick_residual();
		logic [31:0] v;
		case ($urandom_range(0, 6))
			0: begin
				case ($urandom_range(0, 7))
					0: v = 32'h0;
					1: v = 32'h8000_0000;
					2: v = 32'h7FFF_FFFF;
					3: v = 32'h1;
					4: v = 32'hFFFF_FFFF;
					5: v = 32'd500 << FRAC_BITS;
					6: v = (32'd500 << FRAC_BITS) - 1;
					default: v = 32'h0001_0000;
				endcase
			end
			1: v = $urandom;
			2: v = $urandom >> $urandom_range(8, 31);
			3: v = 32'(cur_tun) + 32'($urandom_range(0, 4)) - 32'd2;
			4: v = $urandom_range(0, 600 * 65536);
			default: v = $urandom_range(0, 70000);
		endcase
		if ($urandom_range(0, 1) && v != 32'h8000_0000) v = -v;
		return v;
	endfunction

	initial begin
		logic [31:0] directed [14];
		int n_rand;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOSS_KIND;
		cfg_data  = '0;
		no_idle   = 1'b0;
		cur_tun   = '0;
		residuals_sent = 0;
		phases_run     = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000, 32'h0001_8001, 32'hFFFE_7FFF,
			32'd500 << FRAC_BITS, (32'd500 << FRAC_BITS) - 1, 32'h0000_2000, 32'hFFF0_0000};

		// reset settings (square loss), then the directed corners under logistic and huber
		for (int i = 0; i < 4; i++) send_residual(directed[i], i[0]);
		set_loss(LOSS_LOGISTIC, 17'd32768, 31'h0);
		foreach (directed[i]) send_residual(directed[i], 1'b0);
		set_loss(LOSS_HUBER, 17'd0, 31'h0001_8000);
		for (int i = 5; i < 10; i++) send_residual(directed[i], 1'b1);

		// random phases over many register settings
		for (int ph = 0; ph < 15; ph++) begin
			case (ph)
				0:  set_loss(LOSS_QUANTILE, 17'd32768, 31'h0);
				1:  set_loss(LOSS_QUANTILE, 17'h10000, 31'h0);
				2:  set_loss(LOSS_QUANTILE, 17'd0, 31'h0001_0000);
				3:  set_loss(LOSS_QUANTILE, 17'h1FFFF, 31'h7FFF_FFFF);
				4:  set_loss(LOSS_QUANTILE, 17'($urandom_range(0, 65536)),
						31'($urandom_range(1, 32'h0010_0000)));
				5:  set_loss(LOSS_HUBER, 17'd65536, 31'h0);
				6:  set_loss(LOSS_HUBER, 17'd1, 31'h7FFF_FFFF);
				7:  set_loss(LOSS_HUBER, 17'd99, 31'($urandom));
				8:  set_loss(LOSS_LOGISTIC, 17'd0, 31'h0);
				9:  set_loss(LOSS_LOGISTIC, 17'h1FFFF, 31'h7FFF_FFFF);
				10: set_loss(LOSS_SQUARE, 17'($urandom), 31'($urandom));
				11: set_loss(kind_t'(0), 17'($urandom), 31'($urandom));
				12: set_loss(kind_t'(LOSS_LOGISTIC + 3'd1), 17'd5, 31'h1);
				13: set_loss(kind_t'(LOSS_LOGISTIC + 3'd3), 17'd7, 31'h3);
				default: set_loss(LOSS_LOGISTIC, 17'd32768, 31'h0);
			endcase
			no_idle = (ph % 4 == 2);
			n_rand = (ph >= 10 && ph <= 13) ? 40 : 110;
			for (int i = 0; i < n_rand; i++) begin
				send_residual(pick_residual(), $urandom_range(0, 7) == 0);
				// hold off until every weight is back
				if (i == n_rand / 2 && ph == 3) drain();
			end
			no_idle = 1'b0;
		end

		drain();
		repeat (120) @(negedge clk);
		$display("Covered %0d residuals over %0d register settings, %0d weights checked.",
			residuals_sent, phases_run, weights_seen);
		if (fail_count == 0 && weights_pending == 0) begin
			$display("[irls_loss_weight] OK");
		end else begin
			$display("[irls_loss_weight] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/ilw_pkg.sv
hdl/ilw_taylor.sv
hdl/ilw_div.sv
hdl/ilw_skid.sv
hdl/irls_loss_weight.sv
tb/sv/irls_loss_weight_check.sv
tb/sv/irls_loss_weight_test.sv
